/* rtl/mgf_pkg.sv */
// Shared types, constants and SHA-256 tables for the MGF1 mask generator.
// No dependencies; every other file imports this package.
package mgf_pkg;

  localparam int SEED_CNT_W = 9;   // holds a seed length up to 256
  localparam int SEED_IDX_W = 8;
  localparam int LEN_W      = 10;
  localparam int POS_W      = 9;   // byte position inside a padded message
  localparam int REM_W      = 10;

  typedef struct packed {
    logic                  bank;
    logic [SEED_CNT_W-1:0] seed_len;
    logic                  ovf;
    logic [LEN_W-1:0]      mask_len;
  } job_t;

  typedef struct packed {
    logic                  en;
    logic                  bank;
    logic [SEED_IDX_W-1:0] idx;
    logic [7:0]            data;
  } seed_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } st_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* rtl/mgf_front.sv */
// Front end: mask length register, seed byte buffering and job creation.
// Depends on mgf_pkg; writes the seed RAM held in mgf_back.
module mgf_front import mgf_pkg::*; #(
  parameter int MAX_SEED_BYTES = 64,
  parameter int MAX_MASK_BYTES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [LEN_W-1:0] cfg_mask_length,
  input  logic             accept,
  input  logic [7:0]       seed_byte,
  input  logic             seed_last,
  output seed_wr_t         wr,
  output logic             push,
  output job_t             job
);

  logic [LEN_W-1:0]      len_r;
  logic [SEED_CNT_W-1:0] cnt_r;
  logic                  ovf_r;
  logic                  bank_r;
  logic                  room;
  logic [SEED_CNT_W-1:0] cnt_after;
  logic [LEN_W-1:0]      eff_len;

  assign room      = cnt_r < SEED_CNT_W'(MAX_SEED_BYTES);
  assign cnt_after = room ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_MASK_BYTES)) begin
      eff_len = LEN_W'(MAX_MASK_BYTES);
    end else begin
      eff_len = len_r;
    end
  end

  assign wr.en   = accept && room;
  assign wr.bank = bank_r;
  assign wr.idx  = cnt_r[SEED_IDX_W-1:0];
  assign wr.data = seed_byte;

  assign push          = accept && seed_last;
  assign job.bank      = bank_r;
  assign job.seed_len  = cnt_after;
  assign job.ovf       = ovf_r || !room;
  assign job.mask_len  = eff_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(32);
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_mask_length;
      end
      if (accept) begin
        if (seed_last) begin
          cnt_r  <= '0;
          ovf_r  <= 1'b0;
          bank_r <= !bank_r;
        end else begin
          cnt_r <= cnt_after;
          ovf_r <= ovf_r || !room;
        end
      end
    end
  end

endmodule

/* rtl/mgf_jobq.sv */
// Two-entry job queue between front and back; one entry per seed RAM bank.
// Depends on mgf_pkg for job_t.
module mgf_jobq import mgf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head
);

  job_t       ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("job queue overrun");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("job queue underrun");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count slip");
`endif

endmodule

/* rtl/mgf_back.sv */
// Back end: seed RAM, SHA-256 round engine iterating over counter hashes,
// and mask word emission. Depends on mgf_pkg.
module mgf_back import mgf_pkg::*; #(
  parameter int MAX_SEED_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  seed_wr_t    wr,
  input  logic        job_valid,
  input  job_t        job,
  output logic        pop,
  output logic        out_valid,
  output logic [63:0] out_mask_word,
  output logic [3:0]  out_valid_bytes,
  output logic        out_mask_last,
  output logic        out_seed_overflow
);

  localparam int RAM_DEPTH = 2 * MAX_SEED_BYTES;
  localparam int AW        = $clog2(RAM_DEPTH);

  logic [7:0]    ram [RAM_DEPTH];
  logic [7:0]    ram_q;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  st_t state_r, state_nxt;

  job_t             job_r;
  logic [3:0]       ctr_r;
  logic [2:0]       blk_r;
  logic [2:0]       nblk_r;
  logic [6:0]       lc_r;
  logic [POS_W-1:0] pos_d_r;
  logic [5:0]       t_r;
  logic [1:0]       j_r;
  logic [REM_W-1:0] rem_r;
  logic [511:0]     msg_r;
  logic [31:0]      h_r [8];
  logic [31:0]      v_r [8];

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] n_pos;
  logic [POS_W-1:0] total;
  logic [15:0]      bits;
  logic [7:0]       msg_byte;
  logic [31:0]      w0, w_new, s0, s1, ss0, ss1, ch, mj, t1, t2;
  logic [3:0]       vb;
  logic [REM_W-1:0] rem_after;
  logic [63:0]      word_raw;
  logic [63:0]      word_out;

  // Seed RAM: front writes, back reads with a registered port
  assign waddr = wr.bank ? AW'(MAX_SEED_BYTES) + AW'(wr.idx) : AW'(wr.idx);

  assign pos   = {blk_r, 6'd0} + POS_W'(lc_r[5:0]);
  assign n_pos = POS_W'(job_r.seed_len);

  always_comb begin
    if (pos < n_pos) begin
      raddr = job_r.bank ? AW'(MAX_SEED_BYTES) + AW'(pos[SEED_IDX_W-1:0])
                         : AW'(pos[SEED_IDX_W-1:0]);
    end else begin
      raddr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ram[waddr] <= wr.data;
    end
    ram_q <= ram[raddr];
  end

  // Padded message byte: seed, counter, 0x80, zeros, bit length
  assign total = {nblk_r, 6'd0};
  assign bits  = {4'd0, 12'(job_r.seed_len + 9'd4) << 3};

  always_comb begin
    priority if (pos_d_r < n_pos) begin
      msg_byte = ram_q;
    end else if (pos_d_r == n_pos + POS_W'(3)) begin
      msg_byte = {4'd0, ctr_r};
    end else if (pos_d_r == n_pos + POS_W'(4)) begin
      msg_byte = 8'h80;
    end else if (pos_d_r == total - POS_W'(2)) begin
      msg_byte = bits[15:8];
    end else if (pos_d_r == total - POS_W'(1)) begin
      msg_byte = bits[7:0];
    end else begin
      msg_byte = 8'h00;
    end
  end

  // One round per cycle; schedule word expands in the message window
  assign w0    = msg_r[511:480];
  assign s0    = rotr(msg_r[479:448], 7) ^ rotr(msg_r[479:448], 18) ^ (msg_r[479:448] >> 3);
  assign s1    = rotr(msg_r[63:32], 17) ^ rotr(msg_r[63:32], 19) ^ (msg_r[63:32] >> 10);
  assign w_new = w0 + s0 + msg_r[223:192] + s1;
  assign ss1   = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign t1    = v_r[7] + ss1 + ch + SHA_K[t_r] + w0;
  assign ss0   = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign mj    = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t2    = ss0 + mj;

  // Word emission
  assign vb        = (rem_r >= REM_W'(8)) ? 4'd8 : rem_r[3:0];
  assign rem_after = rem_r - REM_W'(vb);
  assign word_raw  = {h_r[{j_r, 1'b0}], h_r[{j_r, 1'b1}]};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      word_out[63-8*b -: 8] = (4'(b) < vb) ? word_raw[63-8*b -: 8] : 8'h00;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    unique case (state_r)
      ST_IDLE:  if (job_valid) state_nxt = ST_LOAD;
      ST_LOAD:  if (lc_r == 7'd64) state_nxt = ST_ROUND;
      ST_ROUND: if (t_r == 6'd63) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (blk_r + 3'd1 < nblk_r) ? ST_LOAD : ST_EMIT;
      ST_EMIT: begin
        if (rem_after == '0) begin
          pop       = 1'b1;
          state_nxt = ST_IDLE;
        end else if (j_r == 2'd3) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= state_r == ST_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        job_r  <= job;
        nblk_r <= 3'((job.seed_len + 9'd76) >> 6);
        rem_r  <= REM_W'(job.mask_len);
        ctr_r  <= '0;
        blk_r  <= '0;
        lc_r   <= '0;
        for (int i = 0; i < 8; i++) h_r[i] <= SHA_IV[i];
      end
      ST_LOAD: begin
        lc_r    <= lc_r + 7'd1;
        pos_d_r <= pos;
        if (lc_r != 7'd0) begin
          msg_r <= {msg_r[503:0], msg_byte};
        end
        t_r <= '0;
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
      end
      ST_ROUND: begin
        t_r   <= t_r + 6'd1;
        msg_r <= {msg_r[479:0], w_new};
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        blk_r <= blk_r + 3'd1;
        lc_r  <= '0;
        j_r   <= '0;
      end
      ST_EMIT: begin
        out_mask_word     <= word_out;
        out_valid_bytes   <= vb;
        out_mask_last     <= rem_after == '0;
        out_seed_overflow <= job_r.ovf;
        rem_r <= rem_after;
        j_r   <= j_r + 2'd1;
        if (j_r == 2'd3) begin
          // next counter hash starts from the initial hash values
          ctr_r <= ctr_r + 4'd1;
          blk_r <= '0;
          lc_r  <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= SHA_IV[i];
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_EMIT)) else $error("strobe outside emit");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid && out_mask_last) else $error("job retired without last word");
  a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> job_valid) else $error("retire without job");
`endif

endmodule

/* rtl/mgf1_sha256_mask_generator_core.sv */
// MGF1 mask generator over SHA-256.
// Channels: seed bytes transfer on start && !busy, one byte per cycle; the
// byte with in_seed_last set closes the seed and queues a mask job.
// Results: one 64-bit big-endian mask word per out_valid pulse, the final
// word marked by out_mask_last with out_valid_bytes leading bytes valid.
// The receiver cannot stall; words leave at their own pace.
// Config: cfg_mask_length transfers on cfg_valid (cfg_ready is always high),
// 0 reads as 1, values above MAX_MASK_BYTES saturate.
// Each counter hash runs, per 64-byte block (nblk = (seed_len+76)/64 blocks),
// a load, 64 rounds and an add, then emits up to 4 words; a mask takes
// ceil(L/32) such hashes, run one after another on the single round unit.
// Two seed banks let the next seed load while a mask is generated; busy rises
// when both banks hold queued seeds. Reset clears the queue and the engine
// and sets the mask length to 32; the seed RAM needs no clearing.
// Depends on mgf_pkg, mgf_front, mgf_jobq, mgf_back.
module mgf1_sha256_mask_generator_core import mgf_pkg::*; #(
  parameter int MAX_SEED_BYTES = 64,
  parameter int MAX_MASK_BYTES = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       in_seed_byte,
  input  logic             in_seed_last,
  output logic             out_valid,
  output logic [63:0]      out_mask_word,
  output logic [3:0]       out_valid_bytes,
  output logic             out_mask_last,
  output logic             out_seed_overflow,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_mask_length
);

  seed_wr_t wr;
  job_t     push_job;
  job_t     head;
  logic     push;
  logic     pop;
  logic     full;
  logic     head_valid;
  logic     accept;

  assign cfg_ready = 1'b1;
  assign busy      = full;
  assign accept    = start && !busy;

  mgf_front #(
    .MAX_SEED_BYTES(MAX_SEED_BYTES),
    .MAX_MASK_BYTES(MAX_MASK_BYTES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_mask_length(cfg_mask_length),
    .accept         (accept),
    .seed_byte      (in_seed_byte),
    .seed_last      (in_seed_last),
    .wr             (wr),
    .push           (push),
    .job            (push_job)
  );

  mgf_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (full),
    .head_valid(head_valid),
    .head      (head)
  );

  mgf_back #(
    .MAX_SEED_BYTES(MAX_SEED_BYTES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr               (wr),
    .job_valid        (head_valid),
    .job              (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_mask_word    (out_mask_word),
    .out_valid_bytes  (out_valid_bytes),
    .out_mask_last    (out_mask_last),
    .out_seed_overflow(out_seed_overflow)
  );

endmodule

/* bench/mgf1_sha256_mask_generator_core_checker.sv */
// Checker for the MGF1 mask generator: watches seed, mask and config transfers,
// predicts every mask word with its own SHA-256 and compares in order.
// Depends on mgf_pkg for the config width.
module mgf1_sha256_mask_generator_core_checker import mgf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [7:0]       in_seed_byte,
  input  logic             in_seed_last,
  input  logic             out_valid,
  input  logic [63:0]      out_mask_word,
  input  logic [3:0]       out_valid_bytes,
  input  logic             out_mask_last,
  input  logic             out_seed_overflow,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_mask_length,
  output int               fail_count,
  output int               words_pending
);

  localparam int SEED_CAP = 64;
  localparam int MASK_CAP = 512;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nvalid;
    logic        last;
    logic        ovf;
  } mask_word_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [7:0]       seed_buf [SEED_CAP];
  int               seed_len;
  logic             seed_ovf;
  logic [LEN_W-1:0] mask_len;
  mask_word_t       mask_words_due [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  // SHA-256 of the buffered seed followed by the 4-byte big-endian counter.
  function automatic logic [255:0] counter_digest(input int ctr);
    logic [7:0]  msg [128];
    logic [31:0] h [8];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    logic [63:0] bits;
    int          nmsg, total, blk, i;
    logic [255:0] dig;
    nmsg = seed_len + 4;
    total = ((nmsg + 9 + 63) / 64) * 64;
    bits = 64'(nmsg) * 8;
    for (i = 0; i < 128; i++) msg[i] = 8'h00;
    for (i = 0; i < seed_len; i++) msg[i] = seed_buf[i];
    msg[seed_len + 3] = 8'(ctr);
    msg[nmsg] = 8'h80;
    for (i = 0; i < 8; i++) msg[total - 8 + i] = bits[63 - 8*i -: 8];
    for (i = 0; i < 8; i++) h[i] = IV[i];
    for (blk = 0; blk < total; blk += 64) begin
      for (i = 0; i < 16; i++)
        w[i] = {msg[blk+4*i], msg[blk+4*i+1], msg[blk+4*i+2], msg[blk+4*i+3]};
      for (i = 16; i < 64; i++)
        w[i] = w[i-16] + w[i-7]
             + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
             + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
      for (i = 0; i < 8; i++) v[i] = h[i];
      for (i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (i = 0; i < 8; i++) h[i] = h[i] + v[i];
    end
    for (i = 0; i < 8; i++) dig[255 - 32*i -: 32] = h[i];
    return dig;
  endfunction

  // Queue every word of the mask for the current seed, then empty the seed.
  task automatic predict_mask();
    logic [7:0]  mask [MASK_CAP + 32];
    logic [255:0] dig;
    mask_word_t  mw;
    int          len, nhash, nwords, c, k, j, nv;
    len = int'(mask_len);
    if (len == 0) len = 1;
    if (len > MASK_CAP) len = MASK_CAP;
    nhash = (len + 31) / 32;
    for (c = 0; c < nhash; c++) begin
      dig = counter_digest(c);
      for (j = 0; j < 32; j++) mask[32*c + j] = dig[255 - 8*j -: 8];
    end
    nwords = (len + 7) / 8;
    for (k = 0; k < nwords; k++) begin
      nv = (len - 8*k > 8) ? 8 : len - 8*k;
      mw.word = '0;
      for (j = 0; j < 8; j++) mw.word = {mw.word[55:0], (j < nv) ? mask[8*k + j] : 8'h00};
      mw.nvalid = 4'(nv);
      mw.last = (k + 1 == nwords);
      mw.ovf = seed_ovf;
      mask_words_due.push_back(mw);
    end
    seed_len = 0;
    seed_ovf = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mask word mismatch: %s got %h expected %h", what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  // Sample at the falling edge, where every signal has settled for the
  // transfer that happens at the next rising edge.
  always @(negedge clk) begin
    mask_word_t mw;
    if (!rst_n) begin
      seed_len = 0;
      seed_ovf = 1'b0;
      mask_len = LEN_W'(32);
      mask_words_due.delete();
      words_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) mask_len = cfg_mask_length;
      if (out_valid) begin
        if (mask_words_due.size() == 0) begin
          report_mismatch("unexpected word", out_mask_word, 64'h0);
        end else begin
          mw = mask_words_due.pop_front();
          if (out_mask_word !== mw.word) report_mismatch("mask_word", out_mask_word, mw.word);
          if (out_valid_bytes !== mw.nvalid)
            report_mismatch("valid_bytes", 64'(out_valid_bytes), 64'(mw.nvalid));
          if (out_mask_last !== mw.last)
            report_mismatch("mask_last", 64'(out_mask_last), 64'(mw.last));
          if (out_seed_overflow !== mw.ovf)
            report_mismatch("seed_overflow", 64'(out_seed_overflow), 64'(mw.ovf));
        end
      end
      if (start && !busy) begin
        if (seed_len < SEED_CAP) begin
          seed_buf[seed_len] = in_seed_byte;
          seed_len++;
        end else begin
          seed_ovf = 1'b1;
        end
        if (in_seed_last) predict_mask();
      end
      words_pending = mask_words_due.size();
    end
  end

endmodule

/* bench/mgf1_sha256_mask_generator_core_test.sv */
// Testbench top for the MGF1 mask generator: drives seeds and mask lengths,
// gives the verdict. Depends on mgf_pkg, the core and the checker module.
module mgf1_sha256_mask_generator_core_test;
  import mgf_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;
  localparam int DIR_LENS [5] = '{64, 33, 7, 8, 1};

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [7:0]       in_seed_byte;
  logic             in_seed_last;
  logic             out_valid;
  logic [63:0]      out_mask_word;
  logic [3:0]       out_valid_bytes;
  logic             out_mask_last;
  logic             out_seed_overflow;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_mask_length;
  int               fail_count;
  int               words_pending;

  logic seed_xfer, cfg_xfer;
  int   quiet_cycles;
  int   items_sent;
  bit   idle_enable;

  mgf1_sha256_mask_generator_core dut (.*);

  mgf1_sha256_mask_generator_core_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Settled view of each channel for the transfer at the coming rising edge.
  always @(negedge clk) begin
    seed_xfer = start && !busy;
    cfg_xfer = cfg_valid && cfg_ready;
    if (!rst_n || seed_xfer || cfg_xfer || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("mgf1_sha256_mask_generator_core_test: FAIL");
      $finish;
    end
  end

  task automatic write_mask_length(input int len);
    cfg_valid <= 1'b1;
    cfg_mask_length <= LEN_W'(len);
    @(posedge clk);
    while (!cfg_xfer) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_seed_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_enable && $urandom_range(0, 99) < 14) begin
      start <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_seed_byte <= b;
    in_seed_last <= last;
    @(posedge clk);
    while (!seed_xfer) @(posedge clk);
    items_sent++;
    idle_enable = !(items_sent >= 150 && items_sent < 260);
  endtask

  task automatic send_random_seed(input int n);
    for (int i = 0; i < n; i++) send_seed_byte(8'($urandom), i == n - 1);
  endtask

  // Hold start low until every mask word is out, then let the engine drain.
  task automatic drain_masks();
    start <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    int len;
    rst_n = 1'b0;
    start = 1'b0;
    in_seed_byte = 8'h00;
    in_seed_last = 1'b0;
    cfg_valid = 1'b0;
    cfg_mask_length = '0;
    quiet_cycles = 0;
    items_sent = 0;
    idle_enable = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset length, byte extremes, zero and saturating lengths,
    // exact digest multiple, partial final words.
    send_seed_byte(8'h00, 1'b1);
    send_seed_byte(8'hff, 1'b1);
    send_seed_byte(8'ha5, 1'b0);
    send_seed_byte(8'h5a, 1'b1);
    drain_masks();
    write_mask_length(0);
    send_seed_byte(8'h3c, 1'b1);
    drain_masks();
    write_mask_length(1023);
    send_seed_byte(8'hff, 1'b0);
    send_seed_byte(8'h00, 1'b1);
    drain_masks();
    write_mask_length(512);
    send_seed_byte(8'h81, 1'b1);
    drain_masks();
    for (int i = 0; i < 5; i++) begin
      write_mask_length(DIR_LENS[i]);
      send_random_seed(1 + i);
      drain_masks();
    end

    // Random phases: new length each phase, mostly short seeds, some that
    // overflow the seed buffer, final byte included.
    while (items_sent < 460) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = 1023;
        2: len = 512;
        3: len = $urandom_range(1, 8);
        default: len = $urandom_range(9, 100);
      endcase
      write_mask_length(len);
      repeat ($urandom_range(4, 8)) begin
        if ($urandom_range(0, 7) == 0) send_random_seed($urandom_range(64, 68));
        else send_random_seed($urandom_range(1, 24));
      end
      drain_masks();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("mgf1_sha256_mask_generator_core_test: PASS");
    else
      $display("mgf1_sha256_mask_generator_core_test: FAIL");
    $finish;
  end

endmodule
